>>> sv/rist_pkg.sv
// package: opcodes, status codes, sequencer states and result record for the slot table
`default_nettype none
package rist_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int COUNT_BITS_DEF = 16;
	localparam int IDENT_W        = 32;
	localparam int SLOT_OUT_W     = 6;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_DISCARD = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_BAD  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic                    released;
		logic                    was_present;
		status_t                 status;
		logic [IDENT_W-1:0]      ident;
		logic [SLOT_OUT_W-1:0]   slot;
	} res_t;

endpackage
`default_nettype wire

>>> sv/rist_ram.sv
// generic single write port ram with registered read
`default_nettype none
module rist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [AW-1:0]            raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> sv/rist_ctrl.sv
// sequencer: slot scan with one comparator, count update unit, valid bits and fill mark
`default_nettype none
module rist_ctrl #(
	parameter int SLOT_COUNT = rist_pkg::SLOT_COUNT_DEF,
	parameter int COUNT_BITS = rist_pkg::COUNT_BITS_DEF,
	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
	localparam int WORD_W = rist_pkg::IDENT_W + COUNT_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output      logic                                   in_ready,
	input  wire rist_pkg::op_t                          in_opcode,
	input  wire logic [rist_pkg::IDENT_W-1:0]           in_ident,
	input  wire logic [rist_pkg::SLOT_OUT_W-1:0]        in_slot,
	output      logic                                   ram_we,
	output      logic [SLOT_W-1:0]                      ram_waddr,
	output      logic [WORD_W-1:0]                      ram_wdata,
	output      logic [SLOT_W-1:0]                      ram_raddr,
	input  wire logic [WORD_W-1:0]                      ram_rdata,
	output      logic                                   res_valid,
	input  wire logic                                   res_ready,
	output      rist_pkg::res_t                         res
);
	import rist_pkg::*;

	localparam int FILL_W = $clog2(SLOT_COUNT + 1);
	localparam int CMP_W  = (FILL_W > SLOT_OUT_W) ? FILL_W : SLOT_OUT_W;

	state_t                  state_q, state_nxt;
	op_t                     op_q;
	logic [IDENT_W-1:0]      ident_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [FILL_W-1:0]       fill_q;
	logic [SLOT_COUNT-1:0]   valid_q;
	logic [FILL_W-1:0]       scan_q;
	logic [SLOT_W-1:0]       chk_idx_q;
	logic                    chk_live_q;
	logic [SLOT_W-1:0]       blank_q;
	logic                    have_blank_q;
	res_t                    res_q;

	logic [SLOT_W-1:0]       in_idx;
	logic                    in_usable;
	logic                    in_is_add;
	logic [IDENT_W-1:0]      rd_ident;
	logic [COUNT_BITS-1:0]   rd_count;
	logic [COUNT_BITS-1:0]   cnt_step;
	logic [COUNT_BITS-1:0]   cnt_new;
	logic                    is_dec;
	logic                    hit;
	logic                    room;
	logic [SLOT_W-1:0]       target;

	assign in_idx    = SLOT_W'(CMP_W'(in_slot));
	assign in_usable = (CMP_W'(in_slot) < CMP_W'(fill_q)) && valid_q[in_idx];
	assign in_is_add = (in_opcode == OP_ADD);
	assign rd_ident  = ram_rdata[IDENT_W-1:0];
	assign rd_count  = ram_rdata[WORD_W-1:IDENT_W];

	// shared count unit: one adder for increment and decrement, both saturating
	assign is_dec   = (op_q == OP_DISCARD);
	assign cnt_step = rd_count + (is_dec ? {COUNT_BITS{1'b1}} : COUNT_BITS'(1));
	always_comb begin
		if (is_dec) begin
			cnt_new = (rd_count == '0) ? rd_count : cnt_step;
		end else begin
			cnt_new = (rd_count == {COUNT_BITS{1'b1}}) ? rd_count : cnt_step;
		end
	end

	// single identifier comparator
	assign hit    = chk_live_q && valid_q[chk_idx_q] && (rd_ident == ident_q);
	assign room   = have_blank_q || (fill_q != FILL_W'(SLOT_COUNT));
	assign target = have_blank_q ? blank_q : fill_q[SLOT_W-1:0];

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_is_add) begin
						state_nxt = ST_SCAN;
					end else begin
						state_nxt = in_usable ? ST_FETCH : ST_REPLY;
					end
				end
			end
			ST_SCAN: begin
				if (!chk_live_q || hit) begin
					state_nxt = ST_REPLY;
				end
			end
			ST_FETCH: state_nxt = ST_REPLY;
			ST_REPLY: begin
				if (res_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = chk_idx_q;
		ram_wdata = {cnt_new, ident_q};
		ram_raddr = scan_q[SLOT_W-1:0];
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ram_raddr = in_is_add ? '0 : in_idx;
			end
			ST_SCAN: begin
				if (hit) begin
					ram_we = 1'b1;
				end else if (!chk_live_q && room) begin
					ram_we    = 1'b1;
					ram_waddr = target;
					ram_wdata = {COUNT_BITS'(1), ident_q};
				end
			end
			ST_FETCH: begin
				ram_we    = is_dec;
				ram_waddr = slot_q;
				ram_wdata = {cnt_new, rd_ident};
			end
			ST_REPLY: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			valid_q      <= '0;
			scan_q       <= '0;
			chk_live_q   <= 1'b0;
			have_blank_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						scan_q       <= FILL_W'(1);
						chk_live_q   <= (fill_q != '0);
						have_blank_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (chk_live_q) begin
						if (!valid_q[chk_idx_q]) begin
							have_blank_q <= 1'b1;
						end
						if (!hit) begin
							if (scan_q < fill_q) begin
								scan_q     <= scan_q + FILL_W'(1);
								chk_live_q <= 1'b1;
							end else begin
								chk_live_q <= 1'b0;
							end
						end
					end else if (room) begin
						valid_q[target] <= 1'b1;
						if (!have_blank_q) begin
							fill_q <= fill_q + FILL_W'(1);
						end
					end
				end
				ST_FETCH: begin
					if (is_dec && cnt_new == '0) begin
						valid_q[slot_q] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q      <= in_opcode;
					ident_q   <= in_ident;
					slot_q    <= in_idx;
					chk_idx_q <= '0;
					res_q     <= '{released: 1'b0, was_present: 1'b0, status: STAT_BAD,
						ident: '0, slot: '0};
				end
			end
			ST_SCAN: begin
				if (chk_live_q) begin
					if (!valid_q[chk_idx_q]) begin
						blank_q <= chk_idx_q;
					end
					if (hit) begin
						res_q <= '{released: 1'b0, was_present: 1'b1, status: STAT_OK,
							ident: '0, slot: SLOT_OUT_W'(chk_idx_q)};
					end else begin
						chk_idx_q <= scan_q[SLOT_W-1:0];
					end
				end else if (room) begin
					res_q <= '{released: 1'b0, was_present: 1'b0, status: STAT_OK,
						ident: '0, slot: SLOT_OUT_W'(target)};
				end else begin
					res_q <= '{released: 1'b0, was_present: 1'b0, status: STAT_FULL,
						ident: '0, slot: '0};
				end
			end
			ST_FETCH: begin
				if (!is_dec) begin
					res_q <= '{released: 1'b0, was_present: 1'b0, status: STAT_OK,
						ident: rd_ident, slot: '0};
				end else if (cnt_new == '0) begin
					res_q <= '{released: 1'b1, was_present: 1'b0, status: STAT_OK,
						ident: rd_ident, slot: '0};
				end else begin
					res_q <= '{released: 1'b0, was_present: 1'b0, status: STAT_OK,
						ident: '0, slot: '0};
				end
			end
			default: ;
		endcase
	end

	assign res = res_q;

endmodule
`default_nettype wire

>>> sv/refcounted_id_slot_table_core.sv
// top level: reference counted identifier slot table with stream request and result channels
//
// requests enter on s_axis: tuser carries the opcode (add, discard, read), tdata the
// identifier and the slot number. every request gives exactly one result on m_axis:
// tdata holds the slot and the identifier, tuser the status and the present and
// released flags.
// an add scans the slots below the fill mark with one comparator, one slot a cycle
// out of the identifier ram, stopping at a match. a discard or read of a bad slot
// skips the ram fetch and goes straight to the result.
// s_axis_tready is high only while the sequencer is idle; one request is in work
// at a time; the next is taken after the result moves to the output register.
// a result waiting on m_axis holds its data while m_axis_tready is low; a second
// result then waits inside the sequencer, which takes no new request meanwhile.
// reset clears the valid bits, the fill mark and all handshake state at once; the
// identifier and count ram need no clearing, as a slot is read only while valid.
`default_nettype none
module refcounted_id_slot_table_core #(
	parameter int SLOT_COUNT = rist_pkg::SLOT_COUNT_DEF,
	parameter int COUNT_BITS = rist_pkg::COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // ident_value[31:0], slot_number[37:32], zero
	input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [39:0] m_axis_tdata,  // slot_result[5:0], ident_result[37:6], zero
	output      logic [3:0]  m_axis_tuser   // status[1:0], was_present[2], released[3]
);
	import rist_pkg::*;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int WORD_W = IDENT_W + COUNT_BITS;

	logic                ram_we;
	logic [SLOT_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic [SLOT_W-1:0]   ram_raddr;
	logic [WORD_W-1:0]   ram_rdata;
	logic                res_valid;
	logic                res_ready;
	res_t                res;
	logic                out_valid_q;
	res_t                out_q;

	rist_ram #(
		.WIDTH (WORD_W),
		.DEPTH (SLOT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rist_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opcode (op_t'(s_axis_tuser)),
		.in_ident  (s_axis_tdata[31:0]),
		.in_slot   (s_axis_tdata[37:32]),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.ident, out_q.slot};
	assign m_axis_tuser  = {out_q.released, out_q.was_present, out_q.status};

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request taken while a request is in work");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("pending result dropped or changed under stall");

	a_flags_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_q.status != STAT_OK) |->
		(!out_q.was_present && !out_q.released))
		else $error("flag set on a failed request");

endmodule
`default_nettype wire
